FILE: hw/rtl/aslc_pkg.sv
// ----------------------------------------------------------------------------
// aslc_pkg
// Shared types and codes for the station link controller.
// ----------------------------------------------------------------------------
package aslc_pkg;

  localparam int STATIONS_DEF = 256;

  // operations
  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // packet types
  localparam logic [1:0] PT_UNICAST = 2'd0;
  localparam logic [1:0] PT_ACK     = 2'd1;
  localparam logic [1:0] PT_IMM     = 2'd2;

  // actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_ACK       = 4'd1;
  localparam logic [3:0] ACT_MACHINE   = 4'd2;
  localparam logic [3:0] ACT_DELIVER   = 4'd3;
  localparam logic [3:0] ACT_SEND      = 4'd4;
  localparam logic [3:0] ACT_DONE_OK   = 4'd5;
  localparam logic [3:0] ACT_DONE_TO   = 4'd6;
  localparam logic [3:0] ACT_DONE_OTH  = 4'd7;
  localparam logic [3:0] ACT_DUP       = 4'd8;
  localparam logic [3:0] ACT_RANGE     = 4'd9;
  localparam logic [3:0] ACT_TOO_SMALL = 4'd10;
  localparam logic [3:0] ACT_NOT_FOUND = 4'd11;

  // register indexes
  localparam logic [2:0] REG_MY_STATION = 3'd0;
  localparam logic [2:0] REG_RX_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_TX_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_TX_DELAY   = 3'd3;
  localparam logic [2:0] REG_TX_ATTEMPT = 3'd4;
  localparam logic [2:0] REG_PEEK_CODE  = 3'd5;

  localparam logic [7:0] CTL_DELIVER_SET = 8'h80;
  localparam logic [7:0] CTL_SEND_MASK   = 8'h7f;
  localparam logic [31:0] HANDLE_STEP    = 32'd4;

  typedef struct packed {
    logic [15:0] my_station;
    logic [31:0] rx_timeout;
    logic [31:0] tx_timeout;
    logic [31:0] tx_delay;
    logic [7:0]  tx_attempts;
    logic [7:0]  peek_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        in_range;
    logic [15:0] station;
    logic [31:0] source_address;
    logic [1:0]  packet_type;
    logic [7:0]  port;
    logic [7:0]  control;
    logic [31:0] handle;
    logic        buffer_found;
    logic        buffer_fits;
    logic [7:0]  buffer_id;
    logic        second_phase;
  } cmd_t;

  typedef struct packed {
    logic        known;
    logic [31:0] address;
    logic [31:0] rx_last;
    logic [31:0] rx_deadline;
    logic [31:0] tx_count;
    logic [31:0] tx_deadline;
    logic [7:0]  tx_left;
    logic        tx_pending;
    logic [7:0]  tx_buffer;
  } row_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] station;
    logic [7:0]  buffer;
    logic [7:0]  port;
    logic [7:0]  control;
    logic [31:0] handle;
    logic        second_phase;
  } res_t;

endpackage

FILE: hw/rtl/aslc_ram.sv
// ----------------------------------------------------------------------------
// aslc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/aslc_front.sv
// ----------------------------------------------------------------------------
// aslc_front
// Accepts input items, flags station range, and queues them for the back end.
// ----------------------------------------------------------------------------
module aslc_front #(
  parameter int STATIONS = aslc_pkg::STATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [15:0]        station,
  input  logic [31:0]        source_address,
  input  logic [1:0]         packet_type,
  input  logic [7:0]         port,
  input  logic [7:0]         control,
  input  logic [31:0]        handle,
  input  logic               buffer_found,
  input  logic               buffer_fits,
  input  logic [7:0]         buffer_id,
  input  logic               second_phase,
  output logic               q_valid,
  output aslc_pkg::cmd_t     q_head,
  input  logic               q_pop
);

  aslc_pkg::cmd_t slot [2];
  aslc_pkg::cmd_t cmd_in;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign full    = hold || (count == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_head  = slot[rd_ptr];

  always_comb begin
    cmd_in.operation      = operation;
    cmd_in.in_range       = ({1'b0, station} < 17'(STATIONS));
    cmd_in.station        = station;
    cmd_in.source_address = source_address;
    cmd_in.packet_type    = packet_type;
    cmd_in.port           = port;
    cmd_in.control        = control;
    cmd_in.handle         = handle;
    cmd_in.buffer_found   = buffer_found;
    cmd_in.buffer_fits    = buffer_fits;
    cmd_in.buffer_id      = buffer_id;
    cmd_in.second_phase   = second_phase;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (q_pop)   rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/aslc_back.sv
// ----------------------------------------------------------------------------
// aslc_back
// Station table read-modify-write and result sequencing.
// ----------------------------------------------------------------------------
module aslc_back #(
  parameter int STATIONS = aslc_pkg::STATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  aslc_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  aslc_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           clearing,
  output aslc_pkg::res_t res,
  output logic           res_last,
  output logic           res_empty,
  input  logic           res_pop
);

  localparam int IW = $clog2(STATIONS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]     state;
  logic [IW-1:0]  clr_idx;
  logic [31:0]    now;
  aslc_pkg::cmd_t cmd;
  aslc_pkg::row_t rd_row, wr_row;
  aslc_pkg::res_t res_q [3];
  aslc_pkg::res_t res_c [3];
  logic [1:0]     rcnt, ridx, n;
  logic           we;
  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  aslc_pkg::row_t ram_wdata;

  assign clearing  = (state == S_CLEAR);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_empty = (state != S_DRAIN);
  assign res       = res_q[ridx];
  assign res_last  = (ridx == rcnt - 2'd1);

  assign ram_we    = clearing || ((state == S_EXEC) && we);
  assign ram_waddr = clearing ? clr_idx : cmd.station[IW-1:0];
  assign ram_wdata = clearing ? '0 : wr_row;

  aslc_ram #(
    .WIDTH ($bits(aslc_pkg::row_t)),
    .DEPTH (STATIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_head.station[IW-1:0]),
    .rdata (rd_row)
  );

  always_comb begin
    aslc_pkg::res_t blank;
    blank  = '0;
    wr_row = rd_row;
    we     = 1'b0;
    n      = 2'd0;
    for (int i = 0; i < 3; i++) res_c[i] = '0;
    blank.station = cmd.station;

    if (cmd.operation == aslc_pkg::OP_RX) begin
      if (!cmd.in_range) begin
        res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_RANGE; n = n + 2'd1;
      end else if (cmd.station == cfg.my_station) begin
        res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DUP; n = n + 2'd1;
      end else begin
        we = 1'b1;
        if (!rd_row.known) begin
          wr_row.known   = 1'b1;
          wr_row.address = cmd.source_address;
        end
        if (wr_row.address != cmd.source_address) begin
          res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DUP; n = n + 2'd1;
        end else begin
          if (rd_row.tx_pending && cmd.packet_type != aslc_pkg::PT_ACK) begin
            res_c[n] = blank;
            res_c[n].action = aslc_pkg::ACT_DONE_OTH;
            res_c[n].buffer = rd_row.tx_buffer;
            n = n + 2'd1;
            wr_row.tx_pending = 1'b0;
          end
          unique case (cmd.packet_type)
            aslc_pkg::PT_UNICAST: begin
              if (cmd.handle > rd_row.rx_last || now > rd_row.rx_deadline) begin
                wr_row.rx_last     = cmd.handle;
                wr_row.rx_deadline = now + cfg.rx_timeout;
                if (!cmd.buffer_found) begin
                  res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_NOT_FOUND;
                  n = n + 2'd1;
                end else if (!cmd.buffer_fits) begin
                  res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_TOO_SMALL;
                  res_c[n].buffer = cmd.buffer_id;
                  n = n + 2'd1;
                end else begin
                  res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_ACK;
                  res_c[n].port = cmd.port; res_c[n].control = cmd.control;
                  res_c[n].handle = cmd.handle;
                  n = n + 2'd1;
                  res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DELIVER;
                  res_c[n].buffer = cmd.buffer_id; res_c[n].port = cmd.port;
                  res_c[n].control = cmd.control | aslc_pkg::CTL_DELIVER_SET;
                  res_c[n].handle = cmd.handle;
                  n = n + 2'd1;
                end
              end else if (cmd.handle == rd_row.rx_last) begin
                res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_ACK;
                res_c[n].port = cmd.port; res_c[n].control = cmd.control;
                res_c[n].handle = cmd.handle;
                n = n + 2'd1;
              end
            end
            aslc_pkg::PT_ACK: begin
              if (rd_row.tx_pending && cmd.handle == rd_row.tx_count) begin
                res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DONE_OK;
                res_c[n].buffer = rd_row.tx_buffer;
                n = n + 2'd1;
                wr_row.tx_pending = 1'b0;
              end
            end
            aslc_pkg::PT_IMM: begin
              if (cmd.control == cfg.peek_code) begin
                res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_MACHINE;
                res_c[n].port = cmd.port; res_c[n].control = cmd.control;
                res_c[n].handle = cmd.handle;
                n = n + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end else if (!cmd.in_range || !rd_row.known) begin
      res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DONE_TO;
      res_c[n].buffer = cmd.buffer_id;
      n = n + 2'd1;
    end else begin
      logic send;
      send = 1'b0;
      if (cmd.operation == aslc_pkg::OP_REQ) begin
        we = 1'b1;
        if (rd_row.tx_pending && rd_row.tx_buffer != cmd.buffer_id) begin
          res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DONE_TO;
          res_c[n].buffer = rd_row.tx_buffer;
          n = n + 2'd1;
        end
        wr_row.tx_pending = 1'b1;
        wr_row.tx_buffer  = cmd.buffer_id;
        wr_row.tx_left    = cfg.tx_attempts;
        wr_row.tx_count   = rd_row.tx_count + aslc_pkg::HANDLE_STEP;
        if (cfg.tx_delay != 32'd0) wr_row.tx_deadline = now + cfg.tx_delay;
        else send = 1'b1;
      end else if (rd_row.tx_pending && now > rd_row.tx_deadline) begin
        we = 1'b1;
        if (rd_row.tx_left == 8'd0) begin
          res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_DONE_TO;
          res_c[n].buffer = rd_row.tx_buffer;
          n = n + 2'd1;
          wr_row.tx_pending = 1'b0;
        end else begin
          send = 1'b1;
        end
      end
      if (send) begin
        wr_row.tx_deadline = now + cfg.tx_timeout;
        if (wr_row.tx_left != 8'd0) wr_row.tx_left = wr_row.tx_left - 8'd1;
        res_c[n] = blank; res_c[n].action = aslc_pkg::ACT_SEND;
        res_c[n].buffer = wr_row.tx_buffer; res_c[n].port = cmd.port;
        res_c[n].control = cmd.control & aslc_pkg::CTL_SEND_MASK;
        res_c[n].handle = wr_row.tx_count;
        res_c[n].second_phase = cmd.second_phase;
        n = n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_head;
    if (state == S_EXEC) begin
      for (int i = 0; i < 3; i++) res_q[i] <= res_c[i];
      rcnt <= n;
    end
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      now     <= '0;
      ridx    <= 2'd0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(STATIONS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.operation == aslc_pkg::OP_TICK) now <= now + 32'd1;
            else state <= S_EXEC;
          end
        end
        S_EXEC: begin
          ridx  <= 2'd0;
          state <= (n != 2'd0) ? S_DRAIN : S_IDLE;
        end
        S_DRAIN: begin
          if (res_pop) begin
            ridx <= ridx + 2'd1;
            if (res_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/aun_station_link_controller_top.sv
// ----------------------------------------------------------------------------
// aun_station_link_controller_top
// Station link controller: config registers, input queue and table engine.
// ----------------------------------------------------------------------------
// Flow: an accepted item is queued, then popped with its table read, then
//   executed; its results are registered and offered in order.
// Items are taken one at a time: the next is popped only after every result
//   of the current one is popped; a tick is applied at pop, with no execute.
// Reset: synchronous; after rst the table is cleared row by row,
//   full stays high meanwhile; config writes are taken throughout.
module aun_station_link_controller_top #(
  parameter int STATIONS = aslc_pkg::STATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [15:0] station,
  input  logic [31:0] source_address,
  input  logic [1:0]  packet_type,
  input  logic [7:0]  port,
  input  logic [7:0]  control,
  input  logic [31:0] handle,
  input  logic        buffer_found,
  input  logic        buffer_fits,
  input  logic [7:0]  buffer_id,
  input  logic        second_phase,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  action,
  output logic [15:0] out_station,
  output logic [7:0]  out_buffer,
  output logic [7:0]  out_port,
  output logic [7:0]  out_control,
  output logic [31:0] out_handle,
  output logic        out_second_phase,
  output logic        last
);

  aslc_pkg::cfg_t cfg;
  aslc_pkg::cmd_t q_head;
  aslc_pkg::res_t res;
  logic           q_valid, q_pop, clearing;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{my_station: 16'd0, rx_timeout: 32'd0, tx_timeout: 32'd0,
               tx_delay: 32'd0, tx_attempts: 8'd1, peek_code: 8'd0};
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        aslc_pkg::REG_MY_STATION: cfg.my_station  <= pwdata[15:0];
        aslc_pkg::REG_RX_TIMEOUT: cfg.rx_timeout  <= pwdata;
        aslc_pkg::REG_TX_TIMEOUT: cfg.tx_timeout  <= pwdata;
        aslc_pkg::REG_TX_DELAY:   cfg.tx_delay    <= pwdata;
        aslc_pkg::REG_TX_ATTEMPT: cfg.tx_attempts <= pwdata[7:0];
        aslc_pkg::REG_PEEK_CODE:  cfg.peek_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      aslc_pkg::REG_MY_STATION: prdata = {16'd0, cfg.my_station};
      aslc_pkg::REG_RX_TIMEOUT: prdata = cfg.rx_timeout;
      aslc_pkg::REG_TX_TIMEOUT: prdata = cfg.tx_timeout;
      aslc_pkg::REG_TX_DELAY:   prdata = cfg.tx_delay;
      aslc_pkg::REG_TX_ATTEMPT: prdata = {24'd0, cfg.tx_attempts};
      aslc_pkg::REG_PEEK_CODE:  prdata = {24'd0, cfg.peek_code};
      default:                  prdata = 32'd0;
    endcase
  end

  aslc_front #(.STATIONS(STATIONS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .hold           (clearing),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .station        (station),
    .source_address (source_address),
    .packet_type    (packet_type),
    .port           (port),
    .control        (control),
    .handle         (handle),
    .buffer_found   (buffer_found),
    .buffer_fits    (buffer_fits),
    .buffer_id      (buffer_id),
    .second_phase   (second_phase),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  aslc_back #(.STATIONS(STATIONS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res       (res),
    .res_last  (last),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign action           = res.action;
  assign out_station      = res.station;
  assign out_buffer       = res.buffer;
  assign out_port         = res.port;
  assign out_control      = res.control;
  assign out_handle       = res.handle;
  assign out_second_phase = res.second_phase;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the station link controller. A built-in predictor
// tracks the station table and config registers, drives directed receive and
// transmit cases, then random traffic under several register settings, with
// bursty pushes and patterned pops. Each popped result is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] station;
    logic [31:0] source_address;
    logic [1:0]  packet_type;
    logic [7:0]  port;
    logic [7:0]  control;
    logic [31:0] handle;
    logic        buffer_found;
    logic        buffer_fits;
    logic [7:0]  buffer_id;
    logic        second_phase;
  } item_t;

  typedef struct packed {
    aslc_pkg::res_t r;
    logic lst;
  } exp_res_t;

  localparam int NSTN = aslc_pkg::STATIONS_DEF;
  localparam logic [1:0] PT_OTHER = 2'd3;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        push, full, empty, pop;
  logic [1:0]  operation, packet_type;
  logic [15:0] station;
  logic [31:0] source_address, handle;
  logic [7:0]  port, control, buffer_id;
  logic        buffer_found, buffer_fits, second_phase;
  logic [3:0]  action;
  logic [15:0] out_station;
  logic [7:0]  out_buffer, out_port, out_control;
  logic [31:0] out_handle;
  logic        out_second_phase, last;

  aun_station_link_controller_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .operation(operation), .station(station), .source_address(source_address),
    .packet_type(packet_type), .port(port), .control(control), .handle(handle),
    .buffer_found(buffer_found), .buffer_fits(buffer_fits),
    .buffer_id(buffer_id), .second_phase(second_phase),
    .empty(empty), .pop(pop),
    .action(action), .out_station(out_station), .out_buffer(out_buffer),
    .out_port(out_port), .out_control(out_control), .out_handle(out_handle),
    .out_second_phase(out_second_phase), .last(last)
  );

  // predicted config and station table
  logic [15:0] cfg_my_station;
  logic [31:0] cfg_rx_timeout, cfg_tx_timeout, cfg_tx_delay;
  logic [7:0]  cfg_attempts, cfg_peek;
  logic [31:0] now_tick;
  logic        stn_known [NSTN];
  logic [31:0] stn_addr  [NSTN];
  logic [31:0] rx_last   [NSTN];
  logic [31:0] rx_dl     [NSTN];
  logic [31:0] tx_cnt    [NSTN];
  logic [31:0] tx_dl     [NSTN];
  logic [7:0]  tx_left   [NSTN];
  logic        tx_busy   [NSTN];
  logic [7:0]  tx_buf    [NSTN];

  exp_res_t step_q[$];
  exp_res_t result_q[$];
  int errors;
  int burst_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  task automatic stage(input logic [3:0] a, input logic [15:0] st, input logic [7:0] b,
                       input logic [7:0] p, input logic [7:0] c, input logic [31:0] h,
                       input logic sp);
    exp_res_t e;
    e.r = '{a, st, b, p, c, h, sp};
    e.lst = 1'b0;
    step_q.push_back(e);
  endtask

  task automatic tx_send(input int s, input logic [7:0] p, input logic [7:0] c,
                         input logic sp);
    tx_dl[s] = now_tick + cfg_tx_timeout;
    if (tx_left[s] != 0) tx_left[s]--;
    stage(aslc_pkg::ACT_SEND, 16'(s), tx_buf[s], p, c & aslc_pkg::CTL_SEND_MASK,
          tx_cnt[s], sp);
  endtask

  // work out the results of one accepted item and queue them
  task automatic predict(input item_t it);
    int s;
    s = it.station;
    if (it.operation == aslc_pkg::OP_TICK) begin
      now_tick++;
    end else if (it.operation == aslc_pkg::OP_RX) begin
      if (s >= NSTN) begin
        stage(aslc_pkg::ACT_RANGE, it.station, 0, 0, 0, 0, 0);
      end else if (it.station == cfg_my_station) begin
        stage(aslc_pkg::ACT_DUP, it.station, 0, 0, 0, 0, 0);
      end else begin
        if (!stn_known[s]) begin
          stn_known[s] = 1;
          stn_addr[s] = it.source_address;
        end
        if (stn_addr[s] != it.source_address) begin
          stage(aslc_pkg::ACT_DUP, it.station, 0, 0, 0, 0, 0);
        end else begin
          if (tx_busy[s] && it.packet_type != aslc_pkg::PT_ACK) begin
            stage(aslc_pkg::ACT_DONE_OTH, it.station, tx_buf[s], 0, 0, 0, 0);
            tx_busy[s] = 0;
          end
          case (it.packet_type)
            aslc_pkg::PT_UNICAST: begin
              if (it.handle > rx_last[s] || now_tick > rx_dl[s]) begin
                rx_last[s] = it.handle;
                rx_dl[s] = now_tick + cfg_rx_timeout;
                if (!it.buffer_found)
                  stage(aslc_pkg::ACT_NOT_FOUND, it.station, 0, 0, 0, 0, 0);
                else if (!it.buffer_fits)
                  stage(aslc_pkg::ACT_TOO_SMALL, it.station, it.buffer_id, 0, 0, 0, 0);
                else begin
                  stage(aslc_pkg::ACT_ACK, it.station, 0, it.port, it.control,
                        it.handle, 0);
                  stage(aslc_pkg::ACT_DELIVER, it.station, it.buffer_id, it.port,
                        it.control | aslc_pkg::CTL_DELIVER_SET, it.handle, 0);
                end
              end else if (it.handle == rx_last[s]) begin
                stage(aslc_pkg::ACT_ACK, it.station, 0, it.port, it.control, it.handle, 0);
              end
            end
            aslc_pkg::PT_ACK: begin
              if (tx_busy[s] && it.handle == tx_cnt[s]) begin
                stage(aslc_pkg::ACT_DONE_OK, it.station, tx_buf[s], 0, 0, 0, 0);
                tx_busy[s] = 0;
              end
            end
            aslc_pkg::PT_IMM: begin
              if (it.control == cfg_peek)
                stage(aslc_pkg::ACT_MACHINE, it.station, 0, it.port, it.control,
                      it.handle, 0);
            end
            default: ;
          endcase
        end
      end
    end else if (s >= NSTN || !stn_known[s]) begin
      stage(aslc_pkg::ACT_DONE_TO, it.station, it.buffer_id, 0, 0, 0, 0);
    end else if (it.operation == aslc_pkg::OP_REQ) begin
      if (tx_busy[s] && tx_buf[s] != it.buffer_id)
        stage(aslc_pkg::ACT_DONE_TO, it.station, tx_buf[s], 0, 0, 0, 0);
      tx_busy[s] = 1;
      tx_buf[s] = it.buffer_id;
      tx_left[s] = cfg_attempts;
      tx_cnt[s] += aslc_pkg::HANDLE_STEP;
      if (cfg_tx_delay != 0) tx_dl[s] = now_tick + cfg_tx_delay;
      else tx_send(s, it.port, it.control, it.second_phase);
    end else begin
      if (tx_busy[s] && now_tick > tx_dl[s]) begin
        if (tx_left[s] == 0) begin
          stage(aslc_pkg::ACT_DONE_TO, it.station, tx_buf[s], 0, 0, 0, 0);
          tx_busy[s] = 0;
        end else begin
          tx_send(s, it.port, it.control, it.second_phase);
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].lst = 1'b1;
    foreach (step_q[i]) result_q.push_back(step_q[i]);
    step_q.delete();
  endtask

  // push one item, predict at acceptance, then maybe open a gap
  task automatic send_item(input item_t it);
    @(negedge clk);
    {operation, station, source_address, packet_type, port, control, handle,
     buffer_found, buffer_fits, buffer_id, second_phase} = it;
    push = 1;
    do @(posedge clk); while (full);
    predict(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      push = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    if (push) begin
      @(negedge clk);
      push = 0;
    end
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      aslc_pkg::REG_MY_STATION: cfg_my_station = val[15:0];
      aslc_pkg::REG_RX_TIMEOUT: cfg_rx_timeout = val;
      aslc_pkg::REG_TX_TIMEOUT: cfg_tx_timeout = val;
      aslc_pkg::REG_TX_DELAY:   cfg_tx_delay = val;
      aslc_pkg::REG_TX_ATTEMPT: cfg_attempts = val[7:0];
      aslc_pkg::REG_PEEK_CODE:  cfg_peek = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] my, input logic [31:0] rxt,
                           input logic [31:0] txt, input logic [31:0] dly,
                           input logic [7:0] att, input logic [7:0] pk);
    wait_idle();
    reg_write(aslc_pkg::REG_MY_STATION, 32'(my));
    reg_write(aslc_pkg::REG_RX_TIMEOUT, rxt);
    reg_write(aslc_pkg::REG_TX_TIMEOUT, txt);
    reg_write(aslc_pkg::REG_TX_DELAY, dly);
    reg_write(aslc_pkg::REG_TX_ATTEMPT, 32'(att));
    reg_write(aslc_pkg::REG_PEEK_CODE, 32'(pk));
  endtask

  function automatic item_t mk(input logic [1:0] op, input logic [15:0] st,
                               input logic [31:0] addr, input logic [1:0] pt,
                               input logic [31:0] hnd, input logic fnd,
                               input logic fit, input logic [7:0] bid);
    item_t it;
    it = '{op, st, addr, pt, $urandom, $urandom, hnd, fnd, fit, bid, $urandom};
    return it;
  endfunction

  task automatic ticks(input int n);
    repeat (n)
      send_item(mk(aslc_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom, 0, 0, 0));
  endtask

  task automatic test_rx_paths();
    item_t it;
    configure(16'd1, 32'd5, 32'd3, 32'd0, 8'd2, 8'h33);
    send_item(mk(aslc_pkg::OP_RX, 16'd256, 32'h0, aslc_pkg::PT_UNICAST, 0, 1, 1, 0));
    send_item(mk(aslc_pkg::OP_RX, 16'hffff, 32'hffffffff, aslc_pkg::PT_UNICAST, 0, 1, 1, 0));
    send_item(mk(aslc_pkg::OP_RX, 16'd1, 32'h5, aslc_pkg::PT_UNICAST, 0, 1, 1, 0));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST, 32'd10,
                 1, 1, 8'hff));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0002, aslc_pkg::PT_UNICAST, 32'd11,
                 1, 1, 8'h1));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST, 32'd10,
                 1, 1, 8'h2));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST, 32'd5,
                 1, 1, 8'h2));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST, 32'd11,
                 0, 1, 8'h2));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST,
                 32'hffffffff, 1, 0, 8'h3));
    it = mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_IMM, 32'h1234, 1, 1, 0);
    it.control = 8'h33;
    send_item(it);
    it.control = 8'h00;
    send_item(it);
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, PT_OTHER, 0, 1, 1, 0));
    // zero address is learned like any other
    send_item(mk(aslc_pkg::OP_RX, 16'd0, 32'h0, aslc_pkg::PT_UNICAST, 32'd1, 1, 1, 8'h4));
  endtask

  task automatic test_tx_paths();
    send_item(mk(aslc_pkg::OP_REQ, 16'd9, 0, 0, 0, 0, 0, 8'h10));
    send_item(mk(aslc_pkg::OP_POLL, 16'd300, 0, 0, 0, 0, 0, 8'h11));
    send_item(mk(aslc_pkg::OP_REQ, 16'd2, 0, 0, 0, 0, 0, 8'h5));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_ACK, tx_cnt[2] + 1,
                 1, 1, 0));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_ACK, tx_cnt[2],
                 1, 1, 0));
    send_item(mk(aslc_pkg::OP_REQ, 16'd2, 0, 0, 0, 0, 0, 8'h6));
    send_item(mk(aslc_pkg::OP_REQ, 16'd2, 0, 0, 0, 0, 0, 8'h7));
    send_item(mk(aslc_pkg::OP_REQ, 16'd2, 0, 0, 0, 0, 0, 8'h7));
    send_item(mk(aslc_pkg::OP_RX, 16'd2, 32'hcafe0001, aslc_pkg::PT_UNICAST, 32'd20,
                 1, 1, 8'h8));
    send_item(mk(aslc_pkg::OP_REQ, 16'd2, 0, 0, 0, 0, 0, 8'h9));
    send_item(mk(aslc_pkg::OP_POLL, 16'd2, 0, 0, 0, 0, 0, 8'h0));
    ticks(5);
    send_item(mk(aslc_pkg::OP_POLL, 16'd2, 0, 0, 0, 0, 0, 8'h0));
    ticks(5);
    send_item(mk(aslc_pkg::OP_POLL, 16'd2, 0, 0, 0, 0, 0, 8'h0));
    send_item(mk(aslc_pkg::OP_POLL, 16'd2, 0, 0, 0, 0, 0, 8'h0));
  endtask

  function automatic item_t rand_item();
    item_t it;
    int s, r;
    it = {$urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    it.operation = r < 40 ? aslc_pkg::OP_RX : r < 55 ? aslc_pkg::OP_REQ :
                   r < 75 ? aslc_pkg::OP_POLL : aslc_pkg::OP_TICK;
    r = $urandom_range(0, 99);
    if (r < 85) it.station = $urandom_range(0, 7);
    else if (r < 95) it.station = $urandom_range(8, NSTN - 1);
    s = it.station;
    if (s < NSTN) begin
      if (stn_known[s] && $urandom_range(0, 99) < 85) it.source_address = stn_addr[s];
      r = $urandom_range(0, 99);
      it.packet_type = r < 55 ? aslc_pkg::PT_UNICAST : r < 80 ? aslc_pkg::PT_ACK :
                       r < 95 ? aslc_pkg::PT_IMM : PT_OTHER;
      r = $urandom_range(0, 99);
      if (it.packet_type == aslc_pkg::PT_UNICAST) begin
        if (r < 40) it.handle = rx_last[s] + $urandom_range(1, 3);
        else if (r < 60) it.handle = rx_last[s];
        else if (r < 80) it.handle = rx_last[s] - $urandom_range(1, 3);
      end else if (it.packet_type == aslc_pkg::PT_ACK && r < 70) begin
        it.handle = tx_cnt[s];
      end else if (it.packet_type == aslc_pkg::PT_IMM && r < 60) begin
        it.control = cfg_peek;
      end
      if ($urandom_range(0, 99) < 50) it.buffer_id = tx_buf[s];
    end
    it.buffer_found = $urandom_range(0, 99) < 85;
    it.buffer_fits = $urandom_range(0, 99) < 85;
    return it;
  endfunction

  task automatic test_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  task automatic test_config_extremes();
    configure(16'hffff, 32'd0, 32'd0, 32'd0, 8'd255, 8'hff);
    test_random(100);
    configure(16'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 8'd0, 8'd0);
    test_random(100);
    configure(16'd0, 32'd20, 32'd4, 32'd2, 8'd3, $urandom);
    test_random(73);
    configure($urandom_range(0, 7), $urandom_range(0, 30), $urandom_range(0, 8),
              $urandom_range(0, 3), $urandom_range(0, 4), $urandom);
    test_random(100);
  endtask

  // receiver: pop pattern changes every window
  initial begin
    int mode;
    logic [7:0] mask;
    pop = 0;
    forever begin
      mode = $urandom_range(0, 3);
      mask = $urandom;
      for (int i = 0; i < 50; i++) begin
        @(negedge clk);
        case (mode)
          0: pop = 1;
          1: pop = i[0];
          2: pop = $urandom_range(0, 9) < 3;
          default: pop = mask[i % 8];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    exp_res_t e;
    aslc_pkg::res_t got;
    if (!rst && pop && !empty) begin
      got = '{action, out_station, out_buffer, out_port, out_control, out_handle,
              out_second_phase};
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p last=%b", got, last);
      end else begin
        e = result_q.pop_front();
        if (got !== e.r || last !== e.lst) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %p last=%b, got %p last=%b", e.r, e.lst, got, last);
        end
      end
    end
  end

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    push = 0;
    {operation, station, source_address, packet_type, port, control, handle,
     buffer_found, buffer_fits, buffer_id, second_phase} = '0;
    errors = 0;
    burst_left = 0;
    now_tick = 0;
    cfg_my_station = 0; cfg_rx_timeout = 0; cfg_tx_timeout = 0;
    cfg_tx_delay = 0; cfg_attempts = 1; cfg_peek = 0;
    for (int i = 0; i < NSTN; i++) begin
      stn_known[i] = 0; stn_addr[i] = 0; rx_last[i] = 0; rx_dl[i] = 0;
      tx_cnt[i] = 0; tx_dl[i] = 0; tx_left[i] = 0; tx_busy[i] = 0; tx_buf[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_rx_paths();
    test_tx_paths();
    test_config_extremes();
    wait_idle();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: aun_station_link_controller_top.f
hw/rtl/aslc_pkg.sv
hw/rtl/aslc_ram.sv
hw/rtl/aslc_front.sv
hw/rtl/aslc_back.sv
hw/rtl/aun_station_link_controller_top.sv
verif/tb.sv
